>>> hdl/cc20_pkg.sv
package cc20_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_0         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_1         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_2         = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_3         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_LOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_HIGH    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START_COUNTER = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

endpackage

>>> hdl/chacha20_stream_cipher_core.sv
// chacha20 byte stream cipher, one input word gives one output word
// byte inside a block: accept moves to the emit state, which loads the output register
// byte at a block boundary: first waits in the block state for the shared
// quarter-round unit that runs one quarter-round per cycle
// one byte in flight at a time
// reset clears control, config registers and counters; keystream is rebuilt first
module chacha20_stream_cipher_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cc20_pkg::in_word_t                 in_word_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cc20_pkg::out_word_t                out_word_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cc20_pkg::CfgDataW-1:0]      cfg_data_i
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLOCK,
    S_EMIT
  } core_state_e;

  // configuration registers
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q, start_ctr_q;

  // sequencing
  core_state_e state_q;
  logic [5:0]  pos_q;       // byte within the current keystream block
  logic [31:0] blk_idx_q;   // blocks finished in this message
  in_word_t    hold_q;      // accepted word waiting for its keystream byte
  logic        out_valid_q;
  out_word_t   out_word_q;

  logic        in_acc;
  logic        out_free;
  logic        blk_start;
  logic        blk_done;
  words_t      init_w;
  words_t      ks_w;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      key3_q      <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_0:         key0_q      <= cfg_data_i;
        CFG_KEY_1:         key1_q      <= cfg_data_i;
        CFG_KEY_2:         key2_q      <= cfg_data_i;
        CFG_KEY_3:         key3_q      <= cfg_data_i;
        CFG_NONCE_LOW:     nonce_lo_q  <= cfg_data_i;
        CFG_NONCE_HIGH:    nonce_hi_q  <= cfg_data_i[31:0];
        CFG_START_COUNTER: start_ctr_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // initial block state; counter wraps mod 2^32
  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    init_w[4]  = key0_q[31:0];
    init_w[5]  = key0_q[63:32];
    init_w[6]  = key1_q[31:0];
    init_w[7]  = key1_q[63:32];
    init_w[8]  = key2_q[31:0];
    init_w[9]  = key2_q[63:32];
    init_w[10] = key3_q[31:0];
    init_w[11] = key3_q[63:32];
    init_w[12] = start_ctr_q + blk_idx_q;
    init_w[13] = nonce_lo_q[31:0];
    init_w[14] = nonce_lo_q[63:32];
    init_w[15] = nonce_hi_q;
  end

  // one word at a time: input is taken only between words
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  // output register frees when its word is taken
  assign out_free   = !out_valid_q || !out_stall_i;
  // a fresh keystream block is due at every block boundary
  assign blk_start  = in_acc && (pos_q == 6'd0);

  cc20_block #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_block (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(blk_start),
    .init_i (init_w),
    .done_o (blk_done),
    .ks_o   (ks_w)
  );

  // little-endian byte pick from the current keystream word
  assign ks_word = ks_w[pos_q[5:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      blk_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // new word loads as the old one leaves, else the register empties
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= (pos_q == 6'd0) ? S_BLOCK : S_EMIT;
          end
        end
        S_BLOCK: begin
          if (blk_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_word_q.out_byte <= hold_q.data_byte ^ ks_byte;
            out_word_q.out_last <= hold_q.last_byte;
            state_q             <= S_IDLE;
            if (hold_q.last_byte) begin
              // message ends, next byte restarts at the start counter
              pos_q     <= '0;
              blk_idx_q <= '0;
            end else begin
              pos_q <= pos_q + 6'd1;
              if (pos_q == 6'd63) begin
                blk_idx_q <= blk_idx_q + 32'd1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q <= in_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> hdl/cc20_qround.sv
module cc20_qround (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, tb, td;

  always_comb begin
    a1 = a_i + b_i;
    td = d_i ^ a1;
    d1 = {td[15:0], td[31:16]};
    c1 = c_i + d1;
    tb = b_i ^ c1;
    b1 = {tb[19:0], tb[31:20]};
    a2 = a1 + b1;
    td = d1 ^ a2;
    d2 = {td[23:0], td[31:24]};
    c2 = c1 + d2;
    tb = b1 ^ c2;
    b2 = {tb[24:0], tb[31:25]};
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule

>>> hdl/cc20_block.sv
module cc20_block #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cc20_pkg::words_t init_i,
  output logic            done_o,
  output cc20_pkg::words_t ks_o
);
  import cc20_pkg::*;

  localparam int unsigned Steps = DOUBLE_ROUNDS * 8;
  localparam int unsigned StepW = $clog2(Steps);

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_FINAL
  } blk_state_e;

  blk_state_e       state_q;
  logic [StepW-1:0] step_q;
  words_t           ws_q, ws_round, ws_tmp, ws_sum;
  logic             diag;
  logic [31:0]      qa, qb, qc, qd, ra, rb, rc, rd;

  // column steps read taps 0,4,8,12; diagonal steps read 0,5,10,15.
  // rows rotate left after each step so the next group lands on the taps
  assign diag = step_q[2];

  always_comb begin
    qa = ws_q[0];
    qb = diag ? ws_q[5]  : ws_q[4];
    qc = diag ? ws_q[10] : ws_q[8];
    qd = diag ? ws_q[15] : ws_q[12];
  end

  cc20_qround u_qround (
    .a_i(qa), .b_i(qb), .c_i(qc), .d_i(qd),
    .a_o(ra), .b_o(rb), .c_o(rc), .d_o(rd)
  );

  always_comb begin
    ws_tmp    = ws_q;
    ws_tmp[0] = ra;
    if (diag) begin
      ws_tmp[5]  = rb;
      ws_tmp[10] = rc;
      ws_tmp[15] = rd;
    end else begin
      ws_tmp[4]  = rb;
      ws_tmp[8]  = rc;
      ws_tmp[12] = rd;
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        ws_round[r*4 + j] = ws_tmp[r*4 + ((j + 1) % 4)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      ws_sum[i] = ws_q[i] + init_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (start_i) begin
            state_q <= B_ROUND;
            step_q  <= '0;
          end
        end
        B_ROUND: begin
          if (step_q == StepW'(Steps - 1)) begin
            state_q <= B_FINAL;
          end
          step_q <= step_q + 1'b1;
        end
        B_FINAL: state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // working state doubles as the keystream store, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && start_i) begin
      ws_q <= init_i;
    end else if (state_q == B_ROUND) begin
      ws_q <= ws_round;
    end else if (state_q == B_FINAL) begin
      ws_q <= ws_sum;
    end
  end

  assign done_o = (state_q == B_FINAL);
  assign ks_o   = ws_q;

endmodule
